@@ rtl/exl_pkg.sv @@
// ----------------------------------------------------------------------------
// exl_pkg
// Shared types, constants and character helpers of the expression lexer.
// ----------------------------------------------------------------------------
package exl_pkg;

    localparam int POSITION_BITS    = 16;
    localparam int MAX_TOKEN_LENGTH = 255;
    localparam int LEN_BITS         = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_BITS        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    localparam logic [1:0] KW_RETURN = 2'd0;
    localparam logic [1:0] KW_IF     = 2'd1;
    localparam logic [1:0] KW_ELSE   = 2'd2;
    localparam logic [2:0] KW_ALL    = 3'b111;

    localparam int KW_RETURN_LEN = 6;
    localparam int KW_IF_LEN     = 2;
    localparam int KW_ELSE_LEN   = 4;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_NUM   = 2'd1,
        MODE_IDENT = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        KIND_NUM    = 4'd0,
        KIND_IDENT  = 4'd1,
        KIND_RETURN = 4'd2,
        KIND_IF     = 4'd3,
        KIND_ELSE   = 4'd4,
        KIND_PLUS   = 4'd5,
        KIND_MINUS  = 4'd6,
        KIND_SLASH  = 4'd7,
        KIND_LPAREN = 4'd8,
        KIND_RPAREN = 4'd9,
        KIND_ERROR  = 4'd10
    } kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_word_t;

    typedef struct packed {
        kind_t       token_kind;
        logic [15:0] start_offset;
        logic [7:0]  token_length;
        logic [31:0] number_value;
        logic        last_of_run;
    } out_word_t;

    // Tokens produced by one scanned byte, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        out_word_t  tok0;
        out_word_t  tok1;
    } scan_out_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? c + CASE_GAP : c;
    endfunction

    // Character of a keyword at a given index; zero past its end.
    function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        case (kw)
            KW_RETURN: begin
                case (idx)
                    3'd0:    ch = "r";
                    3'd1:    ch = "e";
                    3'd2:    ch = "t";
                    3'd3:    ch = "u";
                    3'd4:    ch = "r";
                    3'd5:    ch = "n";
                    default: ch = 8'h00;
                endcase
            end
            KW_IF: begin
                case (idx)
                    3'd0:    ch = "i";
                    3'd1:    ch = "f";
                    default: ch = 8'h00;
                endcase
            end
            KW_ELSE: begin
                case (idx)
                    3'd0:    ch = "e";
                    3'd1:    ch = "l";
                    3'd2:    ch = "s";
                    3'd3:    ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ rtl/expression_lexer_top.sv @@
// ----------------------------------------------------------------------------
// expression_lexer_top
// Byte-serial expression lexer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// The input channel (s_valid, s_ready, s_data) takes one source byte per word
// with an end-of-input flag. The output channel (m_valid, m_ready, m_data)
// delivers one token per word: kind, start offset, length, number value and a
// flag on the last token caused by a given byte.
// A byte's tokens are registered in the token queue as the byte is accepted.
// The scanner takes one byte per cycle while the queue has room; a byte that
// ends a pending token and also makes a token of its own yields two words,
// which the four entry token queue delivers one after the other.
// s_ready is high while the queue has room for two more tokens, so when the
// receiver stalls the input is held off once three tokens are waiting, and
// bytes keep flowing while fewer results are queued.
// After reset the scanner is idle at offset zero with the queue empty. An
// end-of-input byte flushes any pending token and the next byte starts a new
// source at offset zero.
// ----------------------------------------------------------------------------
module expression_lexer_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  exl_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output exl_pkg::out_word_t m_data
);
    import exl_pkg::*;

    logic      accept;
    logic      room;
    scan_out_t scan_out;

    assign s_ready = room;
    assign accept  = s_valid && room;

    exl_scanner u_scanner (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .in_word  (s_data),
        .scan_out (scan_out)
    );

    exl_token_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (scan_out),
        .room      (room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ rtl/exl_scanner.sv @@
// ----------------------------------------------------------------------------
// exl_scanner
// Scan state registers and the single-pass logic that turns one source byte
// into up to two tokens.
// ----------------------------------------------------------------------------
module exl_scanner (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  exl_pkg::in_word_t in_word,
    output exl_pkg::scan_out_t scan_out
);
    import exl_pkg::*;

    mode_t                    mode_reg,   mode_next;
    logic [POSITION_BITS-1:0] pos_reg,    pos_next;
    logic [POSITION_BITS-1:0] start_reg,  start_next;
    logic [LEN_BITS-1:0]      len_reg,    len_next;
    logic [31:0]              value_reg,  value_next;
    logic [2:0]               cand_reg,   cand_next;

    // State after the byte itself is scanned, before any end-of-input flush.
    mode_t                    mid_mode;
    logic [POSITION_BITS-1:0] mid_start;
    logic [LEN_BITS-1:0]      mid_len;
    logic [31:0]              mid_value;
    logic [2:0]               mid_cand;

    logic       flush_a;
    logic       single_vld;
    kind_t      single_kind;
    logic       flush_b;
    logic [7:0] c;
    logic       eoi;

    assign c   = in_word.in_byte;
    assign eoi = in_word.end_of_input;

    function automatic logic [2:0] track(input logic [2:0] cand, input logic [LEN_BITS-1:0] idx,
                                         input logic [7:0] ch);
        logic [2:0] res;
        logic [7:0] lc;
        lc  = to_lower(ch);
        res = cand;
        if ((idx >= LEN_BITS'(KW_RETURN_LEN)) || (lc != kw_char(KW_RETURN, idx[2:0]))) begin
            res[KW_RETURN] = 1'b0;
        end
        if ((idx >= LEN_BITS'(KW_IF_LEN)) || (lc != kw_char(KW_IF, idx[2:0]))) begin
            res[KW_IF] = 1'b0;
        end
        if ((idx >= LEN_BITS'(KW_ELSE_LEN)) || (lc != kw_char(KW_ELSE, idx[2:0]))) begin
            res[KW_ELSE] = 1'b0;
        end
        return res;
    endfunction

    function automatic out_word_t pending_token(input mode_t m,
                                                input logic [POSITION_BITS-1:0] st,
                                                input logic [LEN_BITS-1:0] ln,
                                                input logic [31:0] val,
                                                input logic [2:0] cand);
        out_word_t   t;
        logic [31:0] st_ext;
        logic [15:0] ln_ext;
        st_ext         = 32'(st);
        ln_ext         = 16'(ln);
        t.start_offset = st_ext[15:0];
        t.token_length = ln_ext[7:0];
        t.last_of_run  = 1'b0;
        t.number_value = 32'd0;
        if (m == MODE_NUM) begin
            t.token_kind   = KIND_NUM;
            t.number_value = val;
        end else if (cand[KW_RETURN] && (ln == LEN_BITS'(KW_RETURN_LEN))) begin
            t.token_kind = KIND_RETURN;
        end else if (cand[KW_IF] && (ln == LEN_BITS'(KW_IF_LEN))) begin
            t.token_kind = KIND_IF;
        end else if (cand[KW_ELSE] && (ln == LEN_BITS'(KW_ELSE_LEN))) begin
            t.token_kind = KIND_ELSE;
        end else begin
            t.token_kind = KIND_IDENT;
        end
        return t;
    endfunction

    always_comb begin : next_state
        logic cont;
        cont = ((mode_reg == MODE_NUM) && is_digit(c)) ||
               ((mode_reg == MODE_IDENT) && (is_letter(c) || is_digit(c)));
        flush_a     = !cont && (mode_reg != MODE_IDLE);
        single_vld  = 1'b0;
        single_kind = KIND_ERROR;
        mid_mode    = mode_reg;
        mid_start   = start_reg;
        mid_len     = len_reg;
        mid_value   = value_reg;
        mid_cand    = cand_reg;
        if (cont) begin
            if (mode_reg == MODE_NUM) begin
                mid_value = (value_reg << 3) + (value_reg << 1) + {24'd0, c - CH_ZERO};
            end else begin
                mid_cand = track(cand_reg, len_reg, c);
            end
            if (len_reg < LEN_BITS'(MAX_TOKEN_LENGTH)) begin
                mid_len = len_reg + 1'b1;
            end
        end else begin
            mid_mode  = MODE_IDLE;
            mid_len   = '0;
            mid_value = 32'd0;
            mid_cand  = KW_ALL;
            if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF)) begin
                single_vld = 1'b0;
            end else if ((c >= CH_ONE) && (c <= CH_NINE)) begin
                mid_mode  = MODE_NUM;
                mid_start = pos_reg;
                mid_len   = LEN_BITS'(1);
                mid_value = {24'd0, c - CH_ZERO};
            end else if (is_letter(c)) begin
                mid_mode  = MODE_IDENT;
                mid_start = pos_reg;
                mid_len   = LEN_BITS'(1);
                mid_cand  = track(KW_ALL, '0, c);
            end else begin
                single_vld = 1'b1;
                case (c)
                    CH_PLUS:   single_kind = KIND_PLUS;
                    CH_MINUS:  single_kind = KIND_MINUS;
                    CH_SLASH:  single_kind = KIND_SLASH;
                    CH_LPAREN: single_kind = KIND_LPAREN;
                    CH_RPAREN: single_kind = KIND_RPAREN;
                    default:   single_kind = KIND_ERROR;
                endcase
            end
        end

        flush_b = eoi && (mid_mode != MODE_IDLE);

        // End of input flushes and starts the next source at offset zero.
        start_next = mid_start;
        if (eoi) begin
            mode_next  = MODE_IDLE;
            len_next   = '0;
            value_next = 32'd0;
            cand_next  = KW_ALL;
            pos_next   = '0;
        end else begin
            mode_next  = mid_mode;
            len_next   = mid_len;
            value_next = mid_value;
            cand_next  = mid_cand;
            pos_next   = pos_reg + 1'b1;
        end
    end

    always_comb begin : token_out
        out_word_t   tok_a;
        out_word_t   tok_s;
        out_word_t   tok_b;
        out_word_t   later;
        logic [31:0] pos_ext;
        pos_ext            = 32'(pos_reg);
        tok_a              = pending_token(mode_reg, start_reg, len_reg, value_reg, cand_reg);
        tok_b              = pending_token(mid_mode, mid_start, mid_len, mid_value, mid_cand);
        tok_s.token_kind   = single_kind;
        tok_s.start_offset = pos_ext[15:0];
        tok_s.token_length = 8'd1;
        tok_s.number_value = 32'd0;
        tok_s.last_of_run  = 1'b0;

        // A single-byte token leaves the scanner idle, so it never meets flush_b.
        later = single_vld ? tok_s : tok_b;

        scan_out.count = 2'(flush_a) + 2'(single_vld) + 2'(flush_b);
        scan_out.tok0  = flush_a ? tok_a : later;
        scan_out.tok1  = later;
        if (scan_out.count == 2'd2) begin
            scan_out.tok1.last_of_run = 1'b1;
        end else begin
            scan_out.tok0.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            value_reg <= 32'd0;
            cand_reg  <= KW_ALL;
        end else if (accept) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            value_reg <= value_next;
            cand_reg  <= cand_next;
        end
    end

    a_two_at_most: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (scan_out.count != 2'd3))
        else $error("scanner produced more than two tokens for one byte");

    a_eoi_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && eoi) |=> ((mode_reg == MODE_IDLE) && (pos_reg == '0)))
        else $error("end of input did not return the scanner to offset zero");

    a_len_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_BITS'(MAX_TOKEN_LENGTH))
        else $error("pending token length above its maximum");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_IDLE) |-> ((len_reg == '0) && (cand_reg == KW_ALL)))
        else $error("idle scanner holds a pending token");

endmodule

@@ rtl/exl_token_queue.sv @@
// ----------------------------------------------------------------------------
// exl_token_queue
// Small token queue that takes up to two tokens a cycle while it has room and delivers one.
// ----------------------------------------------------------------------------
module exl_token_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  exl_pkg::scan_out_t  push_data,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output exl_pkg::out_word_t  m_data
);
    import exl_pkg::*;

    out_word_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic [1:0]           push_cnt;
    logic                 pop;

    assign push_cnt = push ? push_data.count : 2'd0;
    assign pop      = m_valid && m_ready;
    assign m_valid  = (count_reg != '0);
    assign m_data   = slot_reg[rd_ptr_reg];
    // room is high only while there is space for a two-token byte.
    assign room     = (count_reg <= QCNT_BITS'(QUEUE_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_BITS'(push_cnt);
        rd_ptr_next = rd_ptr_reg + QPTR_BITS'(pop);
        count_next  = count_reg + QCNT_BITS'(push_cnt) - QCNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            slot_reg[wr_ptr_reg] <= push_data.tok0;
        end
        if (push_cnt == 2'd2) begin
            slot_reg[wr_ptr_reg + 1'b1] <= push_data.tok1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg + QCNT_BITS'(push_data.count) <= QCNT_BITS'(QUEUE_DEPTH)))
        else $error("token queue overflow");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("token queue count out of range");

    a_pop_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && (push_cnt == 2'd0)) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("token queue did not drain on delivery");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the expression lexer. A queue of source bytes feeds a clocked
// driver. Each byte accepted by the block runs through a scanner model in the
// testbench, which queues the tokens that byte should produce. A clocked
// monitor checks every token word against the oldest queued token. The run
// starts with directed text, then long tokens, and then random sources under
// four idling mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import exl_pkg::*;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    in_word_t  source_bytes[$];
    out_word_t expected_tokens[$];
    out_word_t step_tokens[$];
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        fail_count     = 0;

    string kw_text[3] = '{"return", "if", "else"};

    // Scanner state of the model.
    mode_t                    scan_mode = MODE_IDLE;
    logic [POSITION_BITS-1:0] scan_pos  = '0;
    logic [POSITION_BITS-1:0] tok_start = '0;
    logic [7:0]               tok_len   = '0;
    logic [31:0]              tok_value = '0;
    logic [2:0]               kw_alive  = 3'b111;

    expression_lexer_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #10 aclk = ~aclk;

    function automatic logic digit_ch(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic letter_ch(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic [7:0] lower_ch(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
    endfunction

    task automatic extend_token(input logic [7:0] c);
        if (scan_mode == MODE_NUM) begin
            tok_value = tok_value * 32'd10 + {24'd0, c - 8'h30};
        end else begin
            for (int k = 0; k < 3; k++) begin
                if (tok_len >= kw_text[k].len() || lower_ch(c) != kw_text[k][tok_len])
                    kw_alive[k] = 1'b0;
            end
        end
        if (tok_len < MAX_TOKEN_LENGTH)
            tok_len = tok_len + 8'd1;
    endtask

    task automatic open_token(input mode_t mode, input logic [7:0] c);
        scan_mode = mode;
        tok_start = scan_pos;
        tok_len   = '0;
        tok_value = '0;
        kw_alive  = 3'b111;
        extend_token(c);
    endtask

    task automatic close_token();
        out_word_t tok;
        if (scan_mode != MODE_IDLE) begin
            tok.token_kind   = KIND_NUM;
            tok.start_offset = tok_start;
            tok.token_length = tok_len;
            tok.number_value = '0;
            tok.last_of_run  = 1'b0;
            if (scan_mode == MODE_NUM) begin
                tok.number_value = tok_value;
            end else begin
                tok.token_kind = KIND_IDENT;
                // Keyword lengths differ, so at most one can match.
                for (int k = 0; k < 3; k++) begin
                    if (kw_alive[k] && tok_len == kw_text[k].len())
                        tok.token_kind = kind_t'(KIND_RETURN + k);
                end
            end
            step_tokens.push_back(tok);
            scan_mode = MODE_IDLE;
            tok_len   = '0;
            tok_value = '0;
            kw_alive  = 3'b111;
        end
    endtask

    // Advances the model by one accepted byte and queues its tokens.
    task automatic scan_source_byte(input in_word_t w);
        logic [7:0] c;
        logic       taken;
        out_word_t  tok;
        c     = w.in_byte;
        taken = 1'b0;
        if (scan_mode == MODE_NUM && digit_ch(c)) begin
            extend_token(c);
            taken = 1'b1;
        end else if (scan_mode == MODE_IDENT && (letter_ch(c) || digit_ch(c))) begin
            extend_token(c);
            taken = 1'b1;
        end else begin
            close_token();
        end

        if (!taken) begin
            if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
                // whitespace between tokens
            end else if (c >= "1" && c <= "9") begin
                open_token(MODE_NUM, c);
            end else if (letter_ch(c)) begin
                open_token(MODE_IDENT, c);
            end else begin
                case (c)
                    "+":     tok.token_kind = KIND_PLUS;
                    "-":     tok.token_kind = KIND_MINUS;
                    "/":     tok.token_kind = KIND_SLASH;
                    "(":     tok.token_kind = KIND_LPAREN;
                    ")":     tok.token_kind = KIND_RPAREN;
                    default: tok.token_kind = KIND_ERROR;
                endcase
                tok.start_offset = scan_pos;
                tok.token_length = 8'd1;
                tok.number_value = '0;
                tok.last_of_run  = 1'b0;
                step_tokens.push_back(tok);
            end
        end

        scan_pos = scan_pos + 1'b1;
        if (w.end_of_input) begin
            close_token();
            scan_pos = '0;
        end

        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
        while (step_tokens.size() > 0)
            expected_tokens.push_back(step_tokens.pop_front());
    endtask

    task automatic put_byte(input logic [7:0] b);
        in_word_t w;
        w.in_byte      = b;
        w.end_of_input = 1'b0;
        source_bytes.push_back(w);
    endtask

    task automatic put_text(input string s, input logic ends);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
        if (ends)
            source_bytes[source_bytes.size() - 1].end_of_input = 1'b1;
    endtask

    task automatic mark_end();
        source_bytes[source_bytes.size() - 1].end_of_input = 1'b1;
    endtask

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(1) != 0) ? 8'(8'h61 + $urandom_range(25))
                                        : 8'(8'h41 + $urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return ($urandom_range(4) == 0) ? 8'(8'h30 + $urandom_range(9)) : rand_letter();
    endfunction

    // Driver: presents one source byte per word and feeds accepted ones to the model.
    always @(posedge aclk) begin
        logic     nxt_valid;
        in_word_t nxt_data;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            nxt_valid = s_valid;
            nxt_data  = s_data;
            if (s_valid && s_ready) begin
                scan_source_byte(s_data);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && source_bytes.size() > 0
                && $urandom_range(99) >= send_idle_pct) begin
                nxt_data  = source_bytes.pop_front();
                nxt_valid = 1'b1;
            end
            s_valid <= nxt_valid;
            s_data  <= nxt_data;
        end
    end

    // Monitor: checks each token word against the oldest expected token.
    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected token: kind %0d off %0d len %0d val %0d last %0b",
                                 m_data.token_kind, m_data.start_offset,
                                 m_data.token_length, m_data.number_value,
                                 m_data.last_of_run);
                    fail_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (m_data.token_kind !== want.token_kind
                        || m_data.start_offset !== want.start_offset
                        || m_data.token_length !== want.token_length
                        || m_data.number_value !== want.number_value
                        || m_data.last_of_run !== want.last_of_run) begin
                        if (fail_count < 10) begin
                            $display("token mismatch: expected kind %0d off %0d len %0d val %0d last %0b",
                                     want.token_kind, want.start_offset, want.token_length,
                                     want.number_value, want.last_of_run);
                            $display("                got      kind %0d off %0d len %0d val %0d last %0b",
                                     m_data.token_kind, m_data.start_offset,
                                     m_data.token_length, m_data.number_value,
                                     m_data.last_of_run);
                        end
                        fail_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int          send_mix[4];
        int          recv_mix[4];
        int          target;
        int          ntok;
        int          sel;
        int          n;
        int          k;
        int          variant;
        logic [7:0]  space_set[4];
        logic [7:0]  op_set[5];
        logic [7:0]  ch;

        send_mix  = '{0, 84, 0, 20};
        recv_mix  = '{0, 0, 84, 20};
        space_set = '{8'h20, 8'h09, 8'h0D, 8'h0A};
        op_set    = '{"+", "-", "/", "(", ")"};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            @(negedge aclk);
            send_idle_pct  = send_mix[ph];
            recv_stall_pct = recv_mix[ph];

            if (ph == 0) begin
                // Keywords in mixed case, near misses, operators, the digit zero,
                // a number that wraps, high bytes, and tokens ended by a byte
                // that makes a token of its own.
                put_text("return if else", 1'b1);
                put_text("RETURN If eLSE", 1'b1);
                put_text("ret iff elsex returns i", 1'b1);
                put_text("4294967297+0-/()", 1'b1);
                put_byte(8'hFF);
                mark_end();
                put_byte(8'h80);
                put_text("ab)", 1'b1);
                put_text("12a", 1'b1);
                put_text("x", 1'b1);
                put_byte("7");
                put_byte(8'h09);
                put_byte("8");
                put_byte(8'h0D);
                put_byte("9");
                put_byte(8'h0A);
                mark_end();

                // Lengths past the saturation point.
                put_byte("q");
                for (int i = 0; i < 259; i++)
                    put_byte(rand_alnum());
                put_byte(8'h20);
                put_byte("9");
                for (int i = 0; i < 259; i++)
                    put_byte(8'(8'h30 + $urandom_range(9)));
                mark_end();
            end

            target = source_bytes.size() + 160;
            while (source_bytes.size() < target) begin
                ntok = $urandom_range(1, 12);
                for (int t = 0; t < ntok; t++) begin
                    sel = $urandom_range(99);
                    if (sel < 30) begin
                        n = ($urandom_range(9) == 0) ? $urandom_range(10, 14)
                                                     : $urandom_range(1, 4);
                        put_byte(8'(8'h31 + $urandom_range(8)));
                        for (int i = 1; i < n; i++)
                            put_byte(8'(8'h30 + $urandom_range(9)));
                    end else if (sel < 45) begin
                        // Keyword in random case, sometimes cut short or extended.
                        k       = $urandom_range(2);
                        variant = $urandom_range(3);
                        n       = (variant == 1) ? kw_text[k].len() - 1 : kw_text[k].len();
                        for (int i = 0; i < n; i++) begin
                            ch = kw_text[k][i];
                            put_byte(($urandom_range(1) != 0) ? ch - 8'd32 : ch);
                        end
                        if (variant == 2)
                            put_byte(rand_alnum());
                    end else if (sel < 60) begin
                        n = $urandom_range(1, 8);
                        put_byte(rand_letter());
                        for (int i = 1; i < n; i++)
                            put_byte(rand_alnum());
                    end else if (sel < 82) begin
                        put_byte(op_set[$urandom_range(4)]);
                    end else if (sel < 88) begin
                        put_byte("0");
                    end else begin
                        put_byte(8'($urandom_range(255)));
                    end
                    if ($urandom_range(2) != 0)
                        put_byte(space_set[$urandom_range(3)]);
                end
                mark_end();
            end

            // Hold the next phase until every expected token has come back.
            while (source_bytes.size() != 0 || s_valid || expected_tokens.size() != 0)
                @(posedge aclk);
        end

        repeat (20) @(posedge aclk);
        if (expected_tokens.size() != 0) begin
            $display("%0d expected tokens never arrived", expected_tokens.size());
            fail_count += expected_tokens.size();
        end
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
